/* hdl/lrd_pkg.sv */
// Shared types, constants and the byte-wise CRC-32 step for the log record deframer.
// No dependencies.
package lrd_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned HDR_LAST    = 7;
   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;

   localparam logic [1:0] END_CLEAN = 2'd0;
   localparam logic [1:0] END_TORN  = 2'd1;
   localparam logic [1:0] END_STOP  = 2'd2;

   // One classified byte, handed from the front parser to the CRC back end.
   typedef struct packed {
      logic [7:0]  log_byte;
      logic        is_payload;
      logic        rec_end;
      logic [31:0] exp_crc;
      logic        fin;
      logic        torn;
   } item_type;

   // Reflected CRC-32, one byte (eight shift steps).
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hdl/log_record_deframer_crc_check.sv */
// Log record deframer with CRC-32 check. Bytes of a log enter one per
// transaction on the req_ side, with req_tlast on the last byte of the log.
// Each record is a 4-byte little-endian length, a 4-byte little-endian CRC-32
// (reflected, polynomial 0xEDB88320, init and final xor all ones) and the
// payload. Payload bytes come out as they arrive (rsp_tuser high); the last
// payload byte, or the last header byte of an empty record, carries the
// record verdict. After the first CRC mismatch every byte is dropped until
// the end of the log. The last byte always yields a transaction with
// rsp_tlast high and an end status: clean, torn tail (header or payload cut
// short) or stopped by CRC. Header bytes otherwise give no transaction.
// Rate: one byte per clock cycle sustained unless rsp_tready stalls the output.
// The front parser tracks header/length, a small queue decouples it from the CRC
// back end, whose byte-wide CRC update and compare are combinational. Depends on
// lrd_pkg, lrd_front, lrd_queue, lrd_back.
module log_record_deframer_crc_check #(
   parameter int unsigned QueueDepth = lrd_pkg::QUEUE_DEPTH   // 2 or more
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] log_byte
   input  logic        req_tlast,   // final_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [8] record_end,
                                    // [9] record_good, [11:10] end_status, rest 0
   output logic        rsp_tuser,   // payload_valid
   output logic        rsp_tlast    // log_done
);

   lrd_pkg::item_type fe_item, q_item;
   logic fe_push, q_full, q_valid, q_pop;
   logic [7:0] out_byte;
   logic       out_rend, out_rgood;
   logic [1:0] out_status;

   // front: header parse and byte classification
   lrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .in_ready (req_tready),
      .push     (fe_push),
      .item     (fe_item)
   );

   lrd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_push),
      .wr_item  (fe_item),
      .pop      (q_pop),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_item  (q_item)
   );

   // back: CRC, verdicts, stop handling, registered result
   lrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_pvalid (rsp_tuser),
      .out_rend   (out_rend),
      .out_rgood  (out_rgood),
      .out_done   (rsp_tlast),
      .out_status (out_status)
   );

   assign rsp_tdata = {4'd0, out_status, out_rgood, out_rend, out_byte};

endmodule

/* hdl/lrd_front.sv */
// Front parser: counts header bytes and payload length, tags each byte.
// Depends on lrd_pkg.
module lrd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              q_full,
   output logic              in_ready,
   output logic              push,
   output lrd_pkg::item_type item
);

   typedef enum logic {PH_HEADER, PH_PAYLOAD} phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] exp_crc_ff, exp_crc_in;
   logic [4:0]  shamt;

   assign in_ready = !q_full;
   assign push     = in_valid && !q_full;
   assign shamt    = {hdr_cnt_ff[1:0], 3'b000};

   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      remaining_in = remaining_ff;
      exp_crc_in   = exp_crc_ff;
      item.log_byte   = in_byte;
      item.is_payload = 1'b0;
      item.rec_end    = 1'b0;
      item.exp_crc    = exp_crc_ff;
      item.fin        = in_last;
      item.torn       = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (!hdr_cnt_ff[2]) begin
               remaining_in = (remaining_ff & ~(32'h0000_00FF << shamt))
                              | ({24'd0, in_byte} << shamt);
            end else begin
               exp_crc_in = (exp_crc_ff & ~(32'h0000_00FF << shamt))
                            | ({24'd0, in_byte} << shamt);
            end
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
            item.exp_crc = exp_crc_in;
            if (hdr_cnt_ff == 3'(lrd_pkg::HDR_LAST)) begin
               if (remaining_ff == 32'd0) begin
                  item.rec_end = 1'b1;   // empty record
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            item.is_payload = 1'b1;
            remaining_in    = remaining_ff - 32'd1;
            if (remaining_ff == 32'd1) begin
               item.rec_end = 1'b1;
               phase_in     = PH_HEADER;
            end
         end
         default: ;
      endcase

      item.torn = (phase_in == PH_PAYLOAD) || (hdr_cnt_in != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= 3'd0;
         remaining_ff <= 32'd0;
         exp_crc_ff   <= 32'd0;
      end else if (push) begin
         if (in_last) begin
            phase_ff     <= PH_HEADER;
            hdr_cnt_ff   <= 3'd0;
            remaining_ff <= 32'd0;
            exp_crc_ff   <= 32'd0;
         end else begin
            phase_ff     <= phase_in;
            hdr_cnt_ff   <= hdr_cnt_in;
            remaining_ff <= remaining_in;
            exp_crc_ff   <= exp_crc_in;
         end
      end
   end

endmodule

/* hdl/lrd_queue.sv */
// Short FIFO of tagged bytes between front parser and CRC back end.
// Depends on lrd_pkg.
module lrd_queue #(
   parameter int unsigned Depth = lrd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrd_pkg::item_type wr_item,
   input  logic              pop,
   output logic              full,
   output logic              rd_valid,
   output lrd_pkg::item_type rd_item
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   lrd_pkg::item_type mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full     = (count_ff == CntW'(Depth));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

/* hdl/lrd_back.sv */
// Back end: running CRC, record verdicts, stop after mismatch, output register.
// Depends on lrd_pkg.
module lrd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lrd_pkg::item_type q_item,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_pvalid,
   output logic              out_rend,
   output logic              out_rgood,
   output logic              out_done,
   output logic [1:0]        out_status
);

   logic [31:0] crc_ff, crc_in, crc_upd;
   logic        stopped_ff, stopped_in;
   logic        good, active, emit, slot_free;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        pvalid_ff, rend_ff, rgood_ff, done_ff;
   logic [1:0]  status_ff, status_in;

   assign slot_free = !valid_ff || out_ready;
   assign pop       = q_valid && slot_free;
   assign active    = !stopped_ff;

   always_comb begin
      crc_upd    = q_item.is_payload ? lrd_pkg::crc_byte(crc_ff, q_item.log_byte) : crc_ff;
      good       = ((crc_upd ^ lrd_pkg::CRC_ONES) == q_item.exp_crc);
      stopped_in = stopped_ff || (active && q_item.rec_end && !good);
      emit       = q_item.fin || (active && (q_item.is_payload || q_item.rec_end));
      if (q_item.rec_end || q_item.fin) begin
         crc_in = lrd_pkg::CRC_ONES;
      end else begin
         crc_in = crc_upd;
      end
      if (!q_item.fin) begin
         status_in = lrd_pkg::END_CLEAN;
      end else if (stopped_in) begin
         status_in = lrd_pkg::END_STOP;
      end else if (q_item.torn) begin
         status_in = lrd_pkg::END_TORN;
      end else begin
         status_in = lrd_pkg::END_CLEAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= lrd_pkg::CRC_ONES;
         stopped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (pop) begin
         crc_ff     <= crc_in;
         stopped_ff <= stopped_in && !q_item.fin;
         valid_ff   <= emit;
      end else if (out_ready) begin
         valid_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= (active && q_item.is_payload) ? q_item.log_byte : 8'd0;
         pvalid_ff <= active && q_item.is_payload;
         rend_ff   <= active && q_item.rec_end;
         rgood_ff  <= active && q_item.rec_end && good;
         done_ff   <= q_item.fin;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_pvalid = pvalid_ff;
   assign out_rend   = rend_ff;
   assign out_rgood  = rgood_ff;
   assign out_done   = done_ff;
   assign out_status = status_ff;

endmodule

/* test/tb_log_record_deframer_crc_check.sv */
// Self-checking testbench for log_record_deframer_crc_check: directed and random logs,
// with a byte-level deframer predictor that checks each result transaction.
// Depends on lrd_pkg and the log_record_deframer_crc_check RTL.
module tb_log_record_deframer_crc_check;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 1200;
   localparam int DRAIN_CYCLES   = 20;    // leave room for stray results
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted transaction

   // Parser phase as the predictor tracks it.
   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_PAYLOAD = 2'd1,
      PHASE_STOPPED = 2'd2
   } parse_phase_type;

   // Fields of one result transaction.
   typedef struct packed {
      logic [7:0] payload;
      logic       pvalid;
      logic       rend;
      logic       rgood;
      logic       done;
      logic [1:0] status;
   } rsp_fields_type;

   // One log byte to send. Typed rows carry their own expectation.
   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      logic           typed;
      logic           has_rsp;
      rsp_fields_type rsp;
   } feed_item_type;

   localparam rsp_fields_type NO_RSP = '0;

   // Directed logs:
   //   empty record with stored CRC 0 (good), then a lone final byte (torn header);
   //   one-byte record 0xFF, CRC 0xFF000000, final on the payload byte (clean);
   //   empty record with a wrong CRC, final on its last header byte (CRC stop on
   //   the same byte as the end of the log).
   localparam feed_item_type DIRECTED_ROWS [26] = '{
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, lrd_pkg::END_CLEAN}},
      '{8'h80, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, lrd_pkg::END_TORN}},
      '{8'h01, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, lrd_pkg::END_CLEAN}},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, lrd_pkg::END_STOP}}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] log_byte
   logic        req_tlast  = 1'b0;    // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] payload_byte, [8] record_end,
                                      // [9] record_good, [11:10] end_status
   logic        rsp_tuser;            // payload_valid
   logic        rsp_tlast;            // log_done

   // Bytes to send, and results still owed by the block, oldest first.
   feed_item_type  log_feed [$];
   rsp_fields_type owed_results [$];
   int          feed_idx   = 0;
   int          gap_left   = 0;
   int          stall_left = 0;
   int          errors     = 0;
   int          quiet_cycles = 0;

   // Predictor state.
   parse_phase_type rx_phase;
   logic [2:0]      hdr_count;
   logic [31:0]     rec_len;
   logic [31:0]     rec_crc;
   logic [31:0]     crc_acc;

   log_record_deframer_crc_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reflected CRC-32 register update over one byte, LSB first.
   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] v;
      v = c ^ {24'h0, b};
      repeat (8) v = (v >> 1) ^ (v[0] ? lrd_pkg::CRC_POLY : 32'h0);
      return v;
   endfunction

   function automatic void clear_parser();
      rx_phase  = PHASE_HEADER;
      hdr_count = '0;
      rec_len   = '0;
      rec_crc   = '0;
      crc_acc   = lrd_pkg::CRC_ONES;
   endfunction

   // Verdict on the record just finished; a bad one halts parsing.
   function automatic logic seal_record();
      logic ok;
      ok        = ((crc_acc ^ lrd_pkg::CRC_ONES) == rec_crc);
      hdr_count = '0;
      rec_len   = '0;
      crc_acc   = lrd_pkg::CRC_ONES;
      rx_phase  = ok ? PHASE_HEADER : PHASE_STOPPED;
      return ok;
   endfunction

   // Advances the predictor by one log byte; returns 1 when a result is due.
   function automatic logic deframe_byte(input logic [7:0] b, input logic fin,
                                         output rsp_fields_type r);
      int idx;
      r = '0;
      case (rx_phase)
         PHASE_HEADER: begin
            idx = int'(hdr_count);
            if (idx < 4) rec_len[8*idx +: 8] = b;
            else rec_crc[8*(idx-4) +: 8] = b;
            hdr_count = hdr_count + 3'd1;
            if (idx == 7) begin
               crc_acc = lrd_pkg::CRC_ONES;
               if (rec_len == 32'd0) begin
                  r.rend  = 1'b1;
                  r.rgood = seal_record();
               end else begin
                  rx_phase = PHASE_PAYLOAD;
               end
            end
         end
         PHASE_PAYLOAD: begin
            r.payload = b;
            r.pvalid  = 1'b1;
            crc_acc   = crc_step(crc_acc, b);
            rec_len   = rec_len - 32'd1;
            if (rec_len == 32'd0) begin
               r.rend  = 1'b1;
               r.rgood = seal_record();
            end
         end
         default: ;   // stopped: byte dropped
      endcase
      if (fin) begin
         r.done = 1'b1;
         if (rx_phase != PHASE_HEADER && rx_phase != PHASE_PAYLOAD)
            r.status = lrd_pkg::END_STOP;
         else if (rx_phase == PHASE_PAYLOAD || hdr_count != 3'd0)
            r.status = lrd_pkg::END_TORN;
         else
            r.status = lrd_pkg::END_CLEAN;
         clear_parser();
      end
      return r.pvalid | r.rend | fin;
   endfunction

   // Random logs: mostly well-formed records (some with a corrupted CRC, some
   // cut short or followed by junk), the rest raw noise with arbitrary lengths.
   task automatic add_random_logs(input int target);
      logic [7:0]    bytes [$];
      logic [7:0]    body [$];
      logic [31:0]   len;
      logic [31:0]   crc;
      int            keep;
      feed_item_type it;
      while (log_feed.size() < target) begin
         bytes.delete();
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 4)) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
               crc = lrd_pkg::CRC_ONES;
               body.delete();
               repeat (len) begin
                  body.push_back(8'($urandom_range(0, 255)));
                  crc = crc_step(crc, body[$]);
               end
               crc = crc ^ lrd_pkg::CRC_ONES;
               if ($urandom_range(0, 7) == 0) crc = crc ^ (32'h1 << $urandom_range(0, 31));
               for (int k = 0; k < 4; k++) bytes.push_back(len[8*k +: 8]);
               for (int k = 0; k < 4; k++) bytes.push_back(crc[8*k +: 8]);
               foreach (body[k]) bytes.push_back(body[k]);
            end
            case ($urandom_range(0, 4))
               0: begin
                  if (bytes.size() > 1) begin
                     keep = $urandom_range(1, bytes.size() - 1);
                     while (bytes.size() > keep) void'(bytes.pop_back());
                  end
               end
               1: repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom_range(0, 255)));
               default: ;
            endcase
         end else begin
            repeat ($urandom_range(1, 40)) bytes.push_back(8'($urandom_range(0, 255)));
         end
         foreach (bytes[k]) begin
            it      = '0;
            it.data = bytes[k];
            it.last = (k == bytes.size() - 1);
            log_feed.push_back(it);
         end
      end
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // Both channels in one clocked process: sampling happens on pre-edge values,
   // so checks and predictions never depend on event order within a step.
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      rsp_fields_type predicted;
      logic           has;
      logic           calm;
      if (!reset) begin
         // result side: compare against the oldest owed result
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[7:0], rsp_tuser, rsp_tdata[8], rsp_tdata[9], rsp_tlast,
                    rsp_tdata[11:10]};
            if (owed_results.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected nothing, got %h/%b/%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = owed_results.pop_front();
               check_field("payload_byte", want.payload, got.payload);
               check_field("payload_valid", 8'(want.pvalid), 8'(got.pvalid));
               check_field("record_end", 8'(want.rend), 8'(got.rend));
               check_field("record_good", 8'(want.rgood), 8'(got.rgood));
               check_field("log_done", 8'(want.done), 8'(got.done));
               check_field("end_status", 8'(want.status), 8'(got.status));
            end
         end

         // byte side: predict each accepted transaction
         if (req_tvalid && req_tready) begin
            has = deframe_byte(req_tdata, req_tlast, predicted);
            if (log_feed[feed_idx].typed) begin
               if (log_feed[feed_idx].has_rsp) owed_results.push_back(log_feed[feed_idx].rsp);
            end else if (has) begin
               owed_results.push_back(predicted);
            end
            feed_idx++;
         end

         // no idling in the last tenth of the run, nor in every fourth stretch
         calm = (feed_idx >= log_feed.size() - log_feed.size() / 10) ||
                ((feed_idx / 100) % 4 == 3);

         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (feed_idx >= log_feed.size()) begin
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 7);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= log_feed[feed_idx].data;
               req_tlast  <= log_feed[feed_idx].last;
            end
         end

         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a run of cycles with no transaction on either side is a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clear_parser();
      foreach (DIRECTED_ROWS[i]) log_feed.push_back(DIRECTED_ROWS[i]);
      add_random_logs(log_feed.size() + RANDOM_ITEMS);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (feed_idx < log_feed.size() || owed_results.size() != 0) @(posedge clock);
      // let any stray result show up before closing
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/lrd_pkg.sv
hdl/lrd_front.sv
hdl/lrd_queue.sv
hdl/lrd_back.sv
hdl/log_record_deframer_crc_check.sv
test/tb_log_record_deframer_crc_check.sv
